// ===== hw/rtl/gha_pkg.sv =====
// Shared constants, codes and the bucket selection function of the gap
// histogram accumulator. Used by the channel interfaces and the core.
package gha_pkg;

  localparam int NUM_BUCKETS = 16;
  localparam int MAX_GAP     = 30;

  localparam int VALUE_W = 64;
  localparam int COUNT_W = 64;
  localparam int IDX_W   = 4;

  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int GAP_W  = $clog2(MAX_GAP + 1);
  localparam int SEL_W  = (GAP_W > BKT_W) ? GAP_W : BKT_W;
  localparam int LAST_BKT = NUM_BUCKETS - 1;

  localparam logic ACT_ACCUM = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Even gap in [2, MAX_GAP] maps to gap/2-1, everything else to the last bucket.
  function automatic logic [BKT_W-1:0] pick_bucket(input logic [VALUE_W-1:0] gap);
    logic             in_range;
    logic [SEL_W-1:0] half_m1;
    in_range = (gap >= VALUE_W'(2)) && !gap[0] && (gap <= VALUE_W'(MAX_GAP));
    half_m1  = SEL_W'(gap[GAP_W-1:1]) - SEL_W'(1);
    if (in_range && (half_m1 < SEL_W'(LAST_BKT))) begin
      return BKT_W'(half_m1);
    end
    return BKT_W'(LAST_BKT);
  endfunction

endpackage

// ===== hw/rtl/gha_in_if.sv =====
// Request channel of the gap histogram accumulator: valid/ready plus payload.
// Depends on gha_pkg for field widths.
interface gha_in_if import gha_pkg::*; ;
  logic               valid;
  logic               ready;
  logic               action;
  logic [VALUE_W-1:0] value;
  logic               batch_start;
  logic [IDX_W-1:0]   bucket_index;

  modport source (output valid, action, value, batch_start, bucket_index, input ready);
  modport sink   (input valid, action, value, batch_start, bucket_index, output ready);
endinterface

// ===== hw/rtl/gha_out_if.sv =====
// Result channel of the gap histogram accumulator: valid/ready plus payload.
// Depends on gha_pkg for field widths.
interface gha_out_if import gha_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] bucket_count;
  logic [COUNT_W-1:0] total_count;
  logic               nonempty;

  modport source (output valid, bucket_count, total_count, nonempty, input ready);
  modport sink   (input valid, bucket_count, total_count, nonempty, output ready);
endinterface

// ===== hw/rtl/gap_histogram_accumulator_core.sv =====
// Gap histogram accumulator core: bucket memory with read-modify-write.
// Depends on gha_pkg, gha_in_if and gha_out_if.
//
// Usage:
//   req carries one request per handshake. action ACT_ACCUM supplies the
//   next value of a batch; its gap to the previous value is binned and the
//   running total counted. No gap is formed on batch_start or on the first
//   value after reset. action ACT_READ returns one bucket's count, the
//   total and a non-empty flag on rsp; accumulate requests give no result.
//   Throughput: one request per cycle while req.ready is high. A request
//   passes the accept stage (gap, bucket select, memory read) and then
//   the update stage (increment, write back); the synchronous bucket
//   memory is why the path has both stages. A back-to-back update to the
//   same bucket is forwarded. A read result reaches rsp through the accept
//   stage registers and the output register. Reset clears all bucket valid
//   bits, the total and the previous-value flag; no clearing pass is needed.
//   When rsp stalls, the finished result waits in the output register and
//   requests keep flowing until a second read result would have to wait;
//   req.ready then drops until rsp takes the result.
module gap_histogram_accumulator_core import gha_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  gha_in_if.sink    req,
  gha_out_if.source rsp
);

  logic [COUNT_W-1:0]     mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] ent_valid;

  logic [VALUE_W-1:0] previous_value;
  logic               have_previous;
  logic [COUNT_W-1:0] gap_total;

  logic               s1_valid;
  logic               s1_read;
  logic               s1_oob;
  logic [BKT_W-1:0]   s1_addr;
  logic [COUNT_W-1:0] rdata;
  logic               rd_valid;
  logic               fwd_hit;
  logic [COUNT_W-1:0] fwd_data;

  logic               out_valid;
  logic [COUNT_W-1:0] out_bucket;
  logic [COUNT_W-1:0] out_total;
  logic               out_nonempty;

  logic               stall;
  logic               accept;
  logic               is_read;
  logic               form_gap;
  logic [VALUE_W-1:0] gap;
  logic [BKT_W-1:0]   addr0;
  logic               oob0;
  logic               mem_we;
  logic [COUNT_W-1:0] cur_count;
  logic [COUNT_W-1:0] cnt_next;
  logic               out_load;

  assign stall    = s1_valid && s1_read && out_valid && !rsp.ready;
  assign req.ready = !stall;
  assign accept   = req.valid && req.ready;
  assign is_read  = (req.action == ACT_READ);
  assign form_gap = !is_read && !req.batch_start && have_previous;
  assign gap      = req.value - previous_value;
  assign oob0     = is_read && !(32'(req.bucket_index) < NUM_BUCKETS);
  assign addr0    = is_read ? BKT_W'(req.bucket_index) : pick_bucket(gap);

  assign mem_we    = s1_valid && !s1_read;
  assign cur_count = fwd_hit ? fwd_data : (rd_valid ? rdata : '0);
  assign cnt_next  = cur_count + COUNT_W'(1);
  assign out_load  = s1_valid && s1_read && !stall;

  // accept stage: issue memory read, track previous value
  always_ff @(posedge clk) begin
    if (!stall) begin
      rdata    <= mem[addr0];
      rd_valid <= ent_valid[addr0];
      fwd_hit  <= mem_we && (s1_addr == addr0);
      fwd_data <= cnt_next;
      s1_read  <= is_read;
      s1_oob   <= oob0;
      s1_addr  <= addr0;
    end
    if (accept && !is_read) begin
      previous_value <= req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      have_previous <= 1'b0;
    end else begin
      if (!stall) begin
        s1_valid <= accept && (is_read || form_gap);
      end
      if (accept && !is_read) begin
        have_previous <= 1'b1;
      end
    end
  end

  // update stage: write back incremented count
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[s1_addr] <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      gap_total <= '0;
    end else if (mem_we) begin
      ent_valid[s1_addr] <= 1'b1;
      gap_total          <= gap_total + COUNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bucket   <= s1_oob ? '0 : cur_count;
      out_total    <= gap_total;
      out_nonempty <= (gap_total != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.bucket_count = out_bucket;
  assign rsp.total_count  = out_total;
  assign rsp.nonempty     = out_nonempty;

  a_we_follows_accum: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> $past(accept) && ($past(req.action) == ACT_ACCUM))
    else $error("bucket write without an accumulate request");

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> gap_total == $past(gap_total) + COUNT_W'(1))
    else $error("total did not advance with a bucket write");

  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    !mem_we |=> gap_total == $past(gap_total))
    else $error("total changed without a bucket write");

  a_entry_valid: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> ent_valid[$past(s1_addr)])
    else $error("written bucket not marked valid");

  a_no_stall_write: assert property (@(posedge clk) disable iff (rst)
    stall |-> !mem_we && !accept)
    else $error("stall overlaps a write or an accepted request");

endmodule

// ===== sim/gap_histogram_accumulator_core_tb.sv =====
// Testbench for gap_histogram_accumulator_core: directed and random requests are checked
// against a built-in gap histogram model, with random stalls on both channels.
// Depends on gha_pkg, gha_in_if, gha_out_if and the core RTL.
module gap_histogram_accumulator_core_tb;
  import gha_pkg::*;

  typedef struct {
    logic               action;
    logic [VALUE_W-1:0] value;
    logic               batch_start;
    logic [IDX_W-1:0]   bucket_index;
  } gap_req_t;

  typedef struct {
    logic [COUNT_W-1:0] bucket_count;
    logic [COUNT_W-1:0] total_count;
    logic               nonempty;
  } bucket_read_t;

  logic clk;
  logic rst;

  gha_in_if  req_if ();
  gha_out_if rsp_if ();

  gap_histogram_accumulator_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  logic [COUNT_W-1:0] hist_bins [NUM_BUCKETS];
  logic [COUNT_W-1:0] hist_total;
  logic [VALUE_W-1:0] last_value;
  logic               have_last;
  bucket_read_t       pending_reads [$];

  int src_idle_pct;
  int sink_idle_pct;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  function automatic int bin_for_gap(input logic [VALUE_W-1:0] gap);
    logic [VALUE_W-1:0] half_m1;
    half_m1 = (gap >> 1) - 1;
    if (gap >= 2 && !gap[0] && gap <= MAX_GAP && half_m1 < LAST_BKT) begin
      return int'(half_m1);
    end
    return LAST_BKT;
  endfunction

  // Update the histogram model with one accepted request; reads queue a result.
  task automatic tally_request(input gap_req_t r);
    bucket_read_t exp_rd;
    int           b;
    if (r.action == ACT_READ) begin
      exp_rd.bucket_count = (int'(r.bucket_index) < NUM_BUCKETS) ? hist_bins[r.bucket_index] : '0;
      exp_rd.total_count  = hist_total;
      exp_rd.nonempty     = (hist_total != 0);
      pending_reads.push_back(exp_rd);
    end else begin
      if (!r.batch_start && have_last) begin
        b = bin_for_gap(r.value - last_value);
        hist_bins[b] = hist_bins[b] + 1;
        hist_total   = hist_total + 1;
      end
      last_value = r.value;
      have_last  = 1'b1;
    end
  endtask

  task automatic note_mismatch(input string field, input logic [COUNT_W-1:0] exp_v,
                               input logic [COUNT_W-1:0] got_v);
    if (mismatches < 10) begin
      $display("mismatch on %s: expected %h, got %h", field, exp_v, got_v);
    end
    mismatches++;
  endtask

  // Result checker and random sink stalls.
  always @(posedge clk) begin
    bucket_read_t exp_rd;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_reads.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: bucket_count %h total_count %h",
                   rsp_if.bucket_count, rsp_if.total_count);
        end
        mismatches++;
      end else begin
        exp_rd = pending_reads.pop_front();
        if (rsp_if.bucket_count !== exp_rd.bucket_count)
          note_mismatch("bucket_count", exp_rd.bucket_count, rsp_if.bucket_count);
        if (rsp_if.total_count !== exp_rd.total_count)
          note_mismatch("total_count", exp_rd.total_count, rsp_if.total_count);
        if (rsp_if.nonempty !== exp_rd.nonempty)
          note_mismatch("nonempty", COUNT_W'(exp_rd.nonempty), COUNT_W'(rsp_if.nonempty));
      end
    end
    rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Leaves valid high on return; callers that pause lower it themselves.
  task automatic send_request(input gap_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= r.action;
    req_if.value        <= r.value;
    req_if.batch_start  <= r.batch_start;
    req_if.bucket_index <= r.bucket_index;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    tally_request(r);
  endtask

  task automatic accum(input logic [VALUE_W-1:0] v, input logic start);
    gap_req_t r;
    r.action       = ACT_ACCUM;
    r.value        = v;
    r.batch_start  = start;
    r.bucket_index = IDX_W'($urandom_range(15));
    send_request(r);
  endtask

  task automatic read_bucket(input int idx);
    gap_req_t r;
    r.action       = ACT_READ;
    r.value        = {$urandom, $urandom};
    r.batch_start  = 1'($urandom_range(1));
    r.bucket_index = IDX_W'(idx);
    send_request(r);
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_reads.size() != 0);
  endtask

  task automatic test_first_value();
    accum(64'd100, 1'b0);
    read_bucket(LAST_BKT);
  endtask

  task automatic test_gap_classes();
    accum(64'd102, 1'b0);
    accum(64'd132, 1'b0);
    accum(64'd132, 1'b0);
    accum(64'd133, 1'b0);
    accum(64'd165, 1'b0);
    accum(64'd193, 1'b0);
    accum(64'd5, 1'b0);
    accum('1, 1'b1);
    accum(64'd1, 1'b0);
    accum(64'h8000_0000_0000_0001, 1'b0);
  endtask

  task automatic test_batch_start();
    accum(64'd0, 1'b1);
    accum(64'd2, 1'b0);
  endtask

  task automatic test_bucket_reads();
    gap_req_t r;
    read_bucket(0);
    read_bucket(1);
    read_bucket(13);
    read_bucket(LAST_BKT - 1);
    read_bucket(LAST_BKT);
    r.action       = ACT_READ;
    r.value        = '1;
    r.batch_start  = 1'b1;
    r.bucket_index = '1;
    send_request(r);
    r.value        = '0;
    r.batch_start  = 1'b0;
    r.bucket_index = '0;
    send_request(r);
  endtask

  task automatic test_pause_until_drained();
    read_bucket(0);
    read_bucket(LAST_BKT);
    wait_results_drained();
    accum(64'd1000, 1'b0);
    read_bucket(LAST_BKT);
  endtask

  task automatic test_random_stream(input int src_pct, input int sink_pct, input int n_items);
    int                 sent;
    int                 len;
    int                 pick;
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] gap;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      v = {$urandom, $urandom};
      accum(v, $urandom_range(9) != 0);
      sent++;
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 20) begin
          read_bucket($urandom_range(15));
          sent++;
        end
        pick = $urandom_range(99);
        if (pick < 70)      gap = VALUE_W'(2 * $urandom_range(1, 15));
        else if (pick < 78) gap = VALUE_W'(2 * $urandom_range(16, 40));
        else if (pick < 84) gap = VALUE_W'(2 * $urandom_range(0, 20) + 1);
        else if (pick < 89) gap = '0;
        else if (pick < 94) gap = -VALUE_W'($urandom_range(1, 1000));
        else                gap = {$urandom, $urandom};
        v = v + gap;
        accum(v, 1'b0);
        sent++;
      end
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    req_if.valid        <= 1'b0;
    req_if.action       <= ACT_ACCUM;
    req_if.value        <= '0;
    req_if.batch_start  <= 1'b0;
    req_if.bucket_index <= '0;
    src_idle_pct  = 36;
    sink_idle_pct = 61;
    mismatches    = 0;
    hist_total    = '0;
    last_value    = '0;
    have_last     = 1'b0;
    foreach (hist_bins[i]) hist_bins[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_value();
    test_gap_classes();
    test_batch_start();
    test_bucket_reads();
    test_pause_until_drained();
    test_random_stream(36, 61, 150);
    test_random_stream(61, 36, 150);
    test_random_stream(0, 0, 150);

    wait_results_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
